// ----- sv/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// imh_pkg
// shared types and constants of the indexed min-heap engine
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned CapacityDef     = 1024;
  localparam int unsigned PayloadWidthDef = 32;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned OutPayW         = 32;
  localparam int unsigned PosW            = 10;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SET     = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_MIN     = 3'd4,
    OP_MAX     = 3'd5,
    OP_EXTRACT = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DISPATCH,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_UP_WR_NEXT,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_SWAP,
    ST_DONE
  } state_e;

endpackage

// ----- sv/imh_mem.sv -----
// ----------------------------------------------------------------------------
// imh_mem
// heap slot memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module imh_mem #(
  parameter int unsigned Depth = imh_pkg::CapacityDef,
  parameter int unsigned Width = imh_pkg::KeyW + imh_pkg::PayloadWidthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

// ----- sv/indexed_min_heap_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_engine
// binary min-heap of unique signed keys with value words, one result per op
// ----------------------------------------------------------------------------
// One transaction is taken at a time; its result sits in an output register
// while the next transaction may be accepted, and a new result waits until
// the previous one has been taken. All slots live in one memory with two
// registered read ports and one write port. Ops with a key (add, set, delete,
// search) and max scan the occupied slots one per cycle; a keyed op stops at
// its first match. Sifts walk the tree a level at a time through read,
// compare and write states in either direction. No clearing pass after reset.
module indexed_min_heap_engine #(
  parameter int unsigned CAPACITY      = imh_pkg::CapacityDef,
  parameter int unsigned PAYLOAD_WIDTH = imh_pkg::PayloadWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     opcode_i,
  input  logic signed [imh_pkg::KeyW-1:0] key_i,
  input  logic [imh_pkg::OutPayW-1:0]    payload_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic [imh_pkg::PosW-1:0]       position_o,
  output logic signed [imh_pkg::KeyW-1:0] result_key_o,
  output logic [imh_pkg::OutPayW-1:0]    result_payload_o
);
  import imh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KeyW + PAYLOAD_WIDTH;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [KeyW-1:0]          key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            scan_q, scan_d;
  logic                     found_q, found_d;
  logic [AW-1:0]            at_q, at_d;
  logic [EW-1:0]            best_q, best_d;
  logic [AW-1:0]            cur_q, cur_d;
  logic [EW-1:0]            cur_ent_q, cur_ent_d;
  logic                     up_dir_q, up_dir_d;

  logic                     ov_q, ov_d;
  logic                     st_q, st_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [KeyW-1:0]          rk_q, rk_d;
  logic [OutPayW-1:0]       rp_q, rp_d;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, rda, rdb;

  imh_mem #(.Depth(CAPACITY), .Width(EW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .rdata_a_o(rda), .raddr_b_i(rb), .rdata_b_o(rdb)
  );

  logic accept, out_take;
  assign out_take   = ov_q && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // keys are held with sign flipped so unsigned compare gives signed order
  function automatic logic [KeyW-1:0] kof(input logic [EW-1:0] e);
    kof = e[EW-1 -: KeyW];
  endfunction

  function automatic logic [OutPayW-1:0] pof(input logic [EW-1:0] e);
    logic [63:0] t;
    t = 64'(e[PAYLOAD_WIDTH-1:0]);
    pof = t[OutPayW-1:0];
  endfunction

  logic [CW-1:0] scan_prev;
  logic [AW-1:0] lc, rc, parent;
  logic [CW:0]   lc_w, rc_w;
  logic [AW-1:0] last;
  assign scan_prev = scan_q - CW'(1);
  assign lc_w   = {1'b0, CW'(cur_q)} + {1'b0, CW'(cur_q)} + (CW+1)'(1);
  assign rc_w   = lc_w + (CW+1)'(1);
  assign lc     = lc_w[AW-1:0];
  assign rc     = rc_w[AW-1:0];
  assign parent = (cur_q - AW'(1)) >> 1;
  assign last   = AW'(cnt_q - CW'(1));

  always_comb begin
    state_d = state_q; op_d = op_q; key_d = key_q; pay_d = pay_q;
    cnt_d = cnt_q; scan_d = scan_q; found_d = found_q; at_d = at_q;
    best_d = best_q; cur_d = cur_q; cur_ent_d = cur_ent_q;
    up_dir_d = up_dir_q;
    ov_d = ov_q && !out_take; st_d = st_q; pos_d = pos_q; rk_d = rk_q; rp_d = rp_q;
    we = 1'b0; waddr = '0; wdata = '0; ra = '0; rb = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = op_e'(opcode_i);
          key_d   = key_i ^ {1'b1, {(KeyW-1){1'b0}}};
          pay_d   = PAYLOAD_WIDTH'(payload_i);
          scan_d  = '0;
          found_d = 1'b0;
          at_d    = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue read of slot scan_q, check data of slot scan_q-1
        if (scan_q != '0) begin
          if (op_q == OP_MAX) begin
            if (scan_q == CW'(1) || kof(rda) > kof(best_q)) begin
              best_d = rda; at_d = AW'(scan_prev);
            end
          end else if (!found_q && kof(rda) == key_q) begin
            found_d = 1'b1; at_d = AW'(scan_prev); best_d = rda;
          end
        end
        if (op_q == OP_MIN || op_q == OP_EXTRACT || op_q == OP_NONE) begin
          ra = '0;
          state_d = ST_SCAN_WAIT;
        end else if (scan_q < cnt_q && !(found_d && op_q != OP_MAX)) begin
          ra = AW'(scan_q);
          scan_d = scan_q + CW'(1);
        end else begin
          state_d = ST_DISPATCH;
        end
      end
      ST_SCAN_WAIT: begin
        best_d = rda;
        ra = last;
        state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        // hold until the output register is free
        if (!ov_q || out_take) begin
          st_d = 1'b1; pos_d = '0; rk_d = '0; rp_d = '0;
          state_d = ST_DONE;
          case (op_q)
            OP_ADD: begin
              if (!found_q && cnt_q < CW'(CAPACITY)) begin
                st_d = 1'b0;
                cur_d = AW'(cnt_q);
                cur_ent_d = {key_q, pay_q};
                we = 1'b1; waddr = AW'(cnt_q); wdata = {key_q, pay_q};
                cnt_d = cnt_q + CW'(1);
                state_d = ST_UP_RD;
              end
            end
            OP_SET: begin
              if (found_q) begin
                st_d = 1'b0;
                we = 1'b1; waddr = at_q; wdata = {kof(best_q), pay_q};
              end
            end
            OP_SEARCH: begin
              if (found_q) begin
                st_d = 1'b0; pos_d = PosW'(at_q); rp_d = pof(best_q);
              end
            end
            OP_MIN, OP_MAX: begin
              if (cnt_q != '0) begin
                st_d = 1'b0;
                pos_d = (op_q == OP_MAX) ? PosW'(at_q) : '0;
                rk_d = kof(best_q) ^ {1'b1, {(KeyW-1){1'b0}}};
                rp_d = pof(best_q);
              end
            end
            OP_EXTRACT: begin
              if (cnt_q != '0) begin
                st_d = 1'b0;
                rk_d = kof(best_q) ^ {1'b1, {(KeyW-1){1'b0}}};
                rp_d = pof(best_q);
                at_d = '0;
                ra = last;
                up_dir_d = 1'b0;
                state_d = ST_MOVE_RD;
              end
            end
            OP_DELETE: begin
              if (found_q) begin
                st_d = 1'b0;
                ra = last;
                up_dir_d = 1'b1;
                state_d = ST_MOVE_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOVE_RD: begin
        // rda holds the last entry
        cnt_d = cnt_q - CW'(1);
        cur_d = at_q;
        cur_ent_d = rda;
        if (CW'(at_q) == cnt_q - CW'(1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MOVE_WR;
        end
      end
      ST_MOVE_WR: begin
        we = 1'b1; waddr = cur_q; wdata = cur_ent_q;
        if (up_dir_q && kof(cur_ent_q) < key_q) begin
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        if (cur_q == '0) begin
          state_d = ST_DONE;
        end else begin
          ra = parent;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (kof(rda) > kof(cur_ent_q)) begin
          we = 1'b1; waddr = cur_q; wdata = rda;
          cur_d = parent;
          state_d = ST_UP_WR_NEXT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UP_WR_NEXT: begin
        // sift up writes the carried entry at the new slot after each move
        we = 1'b1; waddr = cur_q; wdata = cur_ent_q;
        state_d = ST_UP_RD;
      end
      ST_DN_RD: begin
        if (lc_w >= {1'b0, cnt_q}) begin
          state_d = ST_DONE;
        end else begin
          ra = lc; rb = rc;
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        state_d = ST_DONE;
        if (rc_w < {1'b0, cnt_q} && kof(rdb) < kof(rda) &&
            kof(rdb) < kof(cur_ent_q)) begin
          we = 1'b1; waddr = cur_q; wdata = rdb;
          cur_d = rc;
          state_d = ST_DN_SWAP;
        end else if (kof(rda) < kof(cur_ent_q)) begin
          we = 1'b1; waddr = cur_q; wdata = rda;
          cur_d = lc;
          state_d = ST_DN_SWAP;
        end
      end
      ST_DN_SWAP: begin
        we = 1'b1; waddr = cur_q; wdata = cur_ent_q;
        state_d = ST_DN_RD;
      end
      ST_DONE: begin
        if (!ov_q || out_take) begin
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; pay_q <= pay_d; scan_q <= scan_d;
    found_q <= found_d; at_q <= at_d; best_q <= best_d; cur_q <= cur_d;
    cur_ent_q <= cur_ent_d; up_dir_q <= up_dir_d;
    st_q <= st_d; pos_q <= pos_d; rk_q <= rk_d; rp_q <= rp_d;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign position_o       = pos_q;
  assign result_key_o     = rk_q;
  assign result_payload_o = rp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("entry count exceeds capacity");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o) else $error("accept while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> position_o == '0 && result_key_o == '0 &&
    result_payload_o == '0) else $error("failed result carries data");
endmodule

// ----- verif/indexed_min_heap_engine_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_engine_tb
// self-checking bench: an in-bench heap predictor feeds a scoreboard of
// expected results; directed corner ops then random op sequences under
// varying sender and receiver idle rates
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_min_heap_engine_tb;
  import imh_pkg::*;

  typedef struct packed {
    logic                     status;
    logic [PosW-1:0]          position;
    logic signed [KeyW-1:0]   rkey;
    logic [OutPayW-1:0]       rpay;
  } heap_resp_t;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned WatchLimit = 200000;

  // predictor state: keys kept with the sign bit flipped for unsigned compare
  class heap_scoreboard;
    logic [KeyW-1:0] hk[Cap];
    logic [OutPayW-1:0] hp[Cap];
    int unsigned cnt;
    heap_resp_t pending[$];
    int unsigned errors;

    function new();
      cnt = 0;
      errors = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [KeyW-1:0] k;
      logic [OutPayW-1:0] p;
      k = hk[a]; p = hp[a];
      hk[a] = hk[b]; hp[a] = hp[b];
      hk[b] = k; hp[b] = p;
    endfunction

    function void sift_up(int unsigned i);
      int unsigned up;
      while (i > 0 && i < cnt) begin
        up = (i - 1) / 2;
        if (hk[up] > hk[i]) begin
          swap_slots(i, up);
          i = up;
        end else break;
      end
    endfunction

    function void sift_down(int unsigned i);
      int unsigned lo;
      while (2 * i + 1 < cnt) begin
        lo = i;
        if (hk[2*i+1] < hk[lo]) lo = 2 * i + 1;
        if (2 * i + 2 < cnt && hk[2*i+2] < hk[lo]) lo = 2 * i + 2;
        if (lo == i) break;
        swap_slots(i, lo);
        i = lo;
      end
    endfunction

    function int find_slot(logic [KeyW-1:0] k);
      for (int unsigned i = 0; i < cnt; i++)
        if (hk[i] == k) return int'(i);
      return -1;
    endfunction

    function void note_op(op_e op, logic signed [KeyW-1:0] key, logic [OutPayW-1:0] pay);
      heap_resp_t r;
      logic [KeyW-1:0] fk;
      logic [KeyW-1:0] moved;
      int at;
      int unsigned last;
      r = '{status: 1'b1, position: '0, rkey: '0, rpay: '0};
      fk = key ^ {1'b1, {(KeyW-1){1'b0}}};
      at = find_slot(fk);
      case (op)
        OP_ADD: if (at < 0 && cnt < Cap) begin
          hk[cnt] = fk; hp[cnt] = pay; cnt++;
          sift_up(cnt - 1);
          r.status = 1'b0;
        end
        OP_SET: if (at >= 0) begin
          hp[at] = pay;
          r.status = 1'b0;
        end
        OP_DELETE: if (at >= 0) begin
          last = cnt - 1;
          moved = hk[last];
          swap_slots(at, last);
          cnt = last;
          if (at < cnt) begin
            if (moved < fk) sift_up(at);
            else sift_down(at);
          end
          r.status = 1'b0;
        end
        OP_SEARCH: if (at >= 0) begin
          r.status = 1'b0; r.position = PosW'(at); r.rpay = hp[at];
        end
        OP_MIN: if (cnt > 0) begin
          r.status = 1'b0; r.rkey = hk[0] ^ {1'b1, {(KeyW-1){1'b0}}}; r.rpay = hp[0];
        end
        OP_MAX: if (cnt > 0) begin
          at = 0;
          for (int unsigned i = 1; i < cnt; i++) if (hk[i] > hk[at]) at = int'(i);
          r.status = 1'b0; r.position = PosW'(at);
          r.rkey = hk[at] ^ {1'b1, {(KeyW-1){1'b0}}}; r.rpay = hp[at];
        end
        OP_EXTRACT: if (cnt > 0) begin
          r.status = 1'b0; r.rkey = hk[0] ^ {1'b1, {(KeyW-1){1'b0}}}; r.rpay = hp[0];
          cnt--;
          hk[0] = hk[cnt]; hp[0] = hp[cnt];
          sift_down(0);
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_resp(heap_resp_t act);
      heap_resp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", act);
        return;
      end
      exp = pending.pop_front();
      if (exp !== act) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d pos=%0d key=%h pay=%h  act st=%0d pos=%0d key=%h pay=%h",
                   exp.status, exp.position, exp.rkey, exp.rpay,
                   act.status, act.position, act.rkey, act.rpay);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic signed [KeyW-1:0] key_i = '0;
  logic [OutPayW-1:0] payload_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o;
  logic [PosW-1:0] position_o;
  logic signed [KeyW-1:0] result_key_o;
  logic [OutPayW-1:0] result_payload_o;

  heap_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  logic signed [KeyW-1:0] key_pool[$];

  always #4 clk_i = ~clk_i;

  indexed_min_heap_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .key_i, .payload_i,
    .out_valid_o, .out_stall_i, .status_o, .position_o, .result_key_o,
    .result_payload_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_resp({status_o, position_o, result_key_o, result_payload_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_op(op_e op, logic signed [KeyW-1:0] key, logic [OutPayW-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    key_i <= key;
    payload_i <= pay;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_op(op, key, pay);
    @(negedge clk_i);
  endtask

  function automatic logic signed [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [KeyW-1:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(3) != 0)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return rand_key();
  endfunction

  task automatic random_ops(int unsigned n);
    int unsigned sel;
    logic signed [KeyW-1:0] k;
    op_e op;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 35) op = OP_ADD;
      else if (sel < 45) op = OP_SET;
      else if (sel < 57) op = OP_DELETE;
      else if (sel < 72) op = OP_SEARCH;
      else if (sel < 80) op = OP_MIN;
      else if (sel < 86) op = OP_MAX;
      else if (sel < 97) op = OP_EXTRACT;
      else op = OP_NONE;
      k = pick_key();
      if (op == OP_ADD && $urandom_range(3) != 0) begin
        k = rand_key();
        key_pool = {key_pool, k};
        if (key_pool.size() > 200) key_pool.delete(0);
      end
      send_op(op, k, $urandom);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  localparam logic signed [KeyW-1:0] KMin = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KMax = {1'b0, {(KeyW-1){1'b1}}};

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty heap, extremes, duplicates, every op
    send_op(OP_MIN, '0, '0);
    send_op(OP_MAX, '0, '0);
    send_op(OP_EXTRACT, '0, '0);
    send_op(OP_SEARCH, 64'sd5, '0);
    send_op(OP_SET, 64'sd5, 32'h1);
    send_op(OP_DELETE, 64'sd5, '0);
    send_op(OP_NONE, KMax, '1);
    send_op(OP_ADD, KMax, '1);
    send_op(OP_ADD, KMin, '0);
    send_op(OP_ADD, KMin, 32'h5);
    send_op(OP_ADD, 64'sd0, 32'hAAAA_5555);
    send_op(OP_ADD, -64'sd1, 32'h5555_AAAA);
    send_op(OP_MIN, '0, '0);
    send_op(OP_MAX, '0, '0);
    send_op(OP_SEARCH, KMax, '0);
    send_op(OP_SET, -64'sd1, '1);
    send_op(OP_DELETE, -64'sd1, '0);
    send_op(OP_DELETE, KMin, '0);
    send_op(OP_EXTRACT, '0, '0);
    send_op(OP_SEARCH, KMin, '0);
    send_op(OP_EXTRACT, '0, '0);
    send_op(OP_EXTRACT, '0, '0);
    drain();

    send_idle_pct = 23; recv_idle_pct = 77;
    random_ops(190);
    drain();
    send_idle_pct = 77; recv_idle_pct = 23;
    random_ops(180);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_ops(190);
    drain();

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/imh_pkg.sv
sv/imh_mem.sv
sv/indexed_min_heap_engine.sv
verif/indexed_min_heap_engine_tb.sv
